/* sv/cfa_pkg.sv */
package cfa_pkg;

  localparam int MaxCharges = 64;
  localparam int FracBits   = 16;

  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;
  localparam logic [1:0] MODE_SPARE  = 2'd3;

  typedef struct packed {
    logic [1:0]   mode;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic         charge_positive;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] field_x;
    logic signed [31:0] field_y;
    logic         saturated;
    logic         append_dropped;
  } out_item_t;

  // one stored charge term request to the term unit
  typedef struct packed {
    logic         vld;
    logic         last;
    logic         neg;
    logic [16:0]  ax;
    logic [16:0]  ay;
    logic         sx;
    logic         sy;
  } term_req_t;

  typedef struct packed {
    logic         vld;
    logic         last;
    logic signed [32:0] tx;
    logic signed [32:0] ty;
    logic         sat;
  } term_rsp_t;

endpackage

/* sv/coulomb_field_accumulator_top.sv */
// coulomb field accumulator
// input channel in_valid/in_ready/in_data carries clear, append and query
// transactions; only a query yields a result on out_valid/out_ready/out_data.
// cfg_we/cfg_wdata writes field_gain (unsigned q16.16); the user must
// write it only while idle, the block does not enforce this. clear and append
// give no result. a query walks the stored charges one at a time through a
// shared term unit: each charge takes a memory read, squaring, a 32 step
// square root and a 63 step divide; a charge at the query point skips the
// root and divide. an empty store goes straight to the result.
// the next transaction can be taken in the cycle after the result is loaded.
// the result sits in an output register and input keeps flowing while it
// waits; a further query result holds in_ready low until out_ready takes the
// first, so a stalled receiver stops the block.
// reset empties the store, clears the dropped flag and sets gain to 1.0;
// the charge memory itself is not cleared, its count alone marks it valid.
module coulomb_field_accumulator_top #(
  parameter int MAX_CHARGES = cfa_pkg::MaxCharges
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cfa_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output cfa_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata
);
  import cfa_pkg::*;

  localparam int AW = (MAX_CHARGES > 1) ? $clog2(MAX_CHARGES) : 1;
  localparam int CW = $clog2(MAX_CHARGES + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [32:0] mem [MAX_CHARGES];
  logic [32:0] rd_r;
  logic [1:0]  state_r;
  logic [CW-1:0] count_r, idx_r;
  logic        dropped_r;
  logic [31:0] gain_r;
  logic signed [15:0] qx_r, qy_r;
  logic signed [31:0] sx_r, sy_r;
  logic        sat_r;
  logic        rd_pend_r;
  term_req_t   req;
  term_rsp_t   rsp;
  logic signed [33:0] nx, ny;
  logic signed [16:0] dx, dy;
  logic        out_load;

  assign in_ready = (state_r == S_IDLE);
  assign out_load = (state_r == S_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) gain_r <= 32'h0001_0000;
    else if (cfg_we) gain_r <= cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready && in_data.mode == MODE_APPEND && count_r < CW'(MAX_CHARGES))
      mem[count_r[AW-1:0]] <= {in_data.pos_x, in_data.pos_y, in_data.charge_positive};
    rd_r <= mem[idx_r[AW-1:0]];
  end

  always_comb begin
    dx = 17'(qx_r) - 17'($signed(rd_r[32:17]));
    dy = 17'(qy_r) - 17'($signed(rd_r[16:1]));
    req.vld  = rd_pend_r;
    req.last = (idx_r == count_r);
    req.neg  = !rd_r[0];
    req.sx   = dx[16];
    req.sy   = dy[16];
    req.ax   = dx[16] ? 17'(-dx) : 17'(dx);
    req.ay   = dy[16] ? 17'(-dy) : 17'(dy);
    nx = 34'(sx_r) + 34'(rsp.tx);
    ny = 34'(sy_r) + 34'(rsp.ty);
  end

  cfa_term u_term (
    .clk  (clk),
    .rst_n(rst_n),
    .gain (gain_r),
    .req  (req),
    .rsp  (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      dropped_r <= 1'b0;
      out_valid <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= (state_r == S_READ);
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            unique case (in_data.mode)
              MODE_CLEAR: begin
                count_r   <= '0;
                dropped_r <= 1'b0;
              end
              MODE_APPEND: begin
                if (count_r < CW'(MAX_CHARGES)) count_r <= count_r + CW'(1);
                else dropped_r <= 1'b1;
              end
              MODE_QUERY: begin
                qx_r  <= in_data.pos_x;
                qy_r  <= in_data.pos_y;
                sx_r  <= '0;
                sy_r  <= '0;
                sat_r <= 1'b0;
                idx_r <= '0;
                state_r <= (count_r == '0) ? S_DONE : S_READ;
              end
              default: ;
            endcase
          end
        end
        S_READ: begin
          idx_r     <= idx_r + CW'(1);
          state_r   <= S_WAIT;
        end
        S_WAIT: begin
          if (rsp.vld) begin
            sx_r <= (nx > 34'sd2147483647) ? 32'sh7fffffff :
                    (nx < -34'sd2147483648) ? 32'sh80000000 : 32'(nx);
            sy_r <= (ny > 34'sd2147483647) ? 32'sh7fffffff :
                    (ny < -34'sd2147483648) ? 32'sh80000000 : 32'(ny);
            sat_r <= sat_r | rsp.sat | (nx > 34'sd2147483647) | (nx < -34'sd2147483648)
                     | (ny > 34'sd2147483647) | (ny < -34'sd2147483648);
            state_r <= rsp.last ? S_DONE : S_READ;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_data.field_x <= sx_r;
            out_data.field_y <= sy_r;
            out_data.saturated <= sat_r;
            out_data.append_dropped <= dropped_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

/* sv/cfa_term.sv */
module cfa_term (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [31:0]      gain,
  input  cfa_pkg::term_req_t req,
  output cfa_pkg::term_rsp_t rsp
);
  import cfa_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQ   = 4'd1;
  localparam logic [3:0] S_SUM  = 4'd2;
  localparam logic [3:0] S_ROOT = 4'd3;
  localparam logic [3:0] S_DEN  = 4'd4;
  localparam logic [3:0] S_NUMX = 4'd5;
  localparam logic [3:0] S_NUMY = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0]  state_r, state_nxt;
  term_req_t   q_r;
  logic [33:0] ax2_r, ay2_r;
  logic [34:0] r2_r;
  logic [63:0] rad_r;
  logic [31:0] root_r;
  logic [63:0] rem_r;
  logic [5:0]  cnt_r;
  logic [66:0] den_r;
  logic [62:0] numx_r, numy_r;
  logic [62:0] qx_r, qy_r;
  logic [66:0] remx_r, remy_r;

  logic [65:0] trial;
  logic [63:0] rem_sh;
  logic [66:0] rx_sh, ry_sh;
  logic [63:0] gx_prod, gy_prod;
  logic        ovx, ovy;
  logic [30:0] magx, magy;

  always_comb begin
    rem_sh  = {rem_r[61:0], rad_r[63:62]};
    trial   = {2'b0, rem_sh} - {32'b0, root_r, 2'b01};
    rx_sh   = {remx_r[65:0], numx_r[62]};
    ry_sh   = {remy_r[65:0], numy_r[62]};
    gx_prod = {32'b0, gain} * {47'b0, q_r.ax};
    gy_prod = {32'b0, gain} * {47'b0, q_r.ay};
    ovx     = (qx_r > 63'd2147483647);
    ovy     = (qy_r > 63'd2147483647);
    magx    = ovx ? 31'h7fffffff : qx_r[30:0];
    magy    = ovy ? 31'h7fffffff : qy_r[30:0];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (req.vld) state_nxt = S_SQ;
      S_SQ:   state_nxt = S_SUM;
      S_SUM:  state_nxt = (ax2_r == '0 && ay2_r == '0) ? S_OUT : S_ROOT;
      S_ROOT: if (cnt_r == 6'd31) state_nxt = S_DEN;
      S_DEN:  state_nxt = S_NUMX;
      S_NUMX: state_nxt = S_NUMY;
      S_NUMY: state_nxt = S_DIV;
      S_DIV:  if (cnt_r == 6'd62) state_nxt = S_OUT;
      S_OUT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsp.vld <= 1'b0;
    end else begin
      rsp.vld <= (state_r == S_OUT);
      unique case (state_r)
        S_IDLE: begin
          q_r <= req;
        end
        S_SQ: begin
          ax2_r <= q_r.ax * q_r.ax;
          ay2_r <= q_r.ay * q_r.ay;
        end
        S_SUM: begin
          r2_r   <= {1'b0, ax2_r} + {1'b0, ay2_r};
          rad_r  <= ({29'b0, ({1'b0, ax2_r} + {1'b0, ay2_r})}) << 28;
          root_r <= '0;
          rem_r  <= '0;
          cnt_r  <= '0;
        end
        S_ROOT: begin
          if (!trial[65]) begin
            rem_r  <= trial[63:0];
            root_r <= {root_r[30:0], 1'b1};
          end else begin
            rem_r  <= rem_sh;
            root_r <= {root_r[30:0], 1'b0};
          end
          rad_r <= {rad_r[61:0], 2'b00};
          cnt_r <= cnt_r + 6'd1;
        end
        S_DEN: begin
          den_r <= {32'b0, r2_r} * {35'b0, root_r};
        end
        S_NUMX: begin
          numx_r <= {gx_prod[48:0], 14'b0};
        end
        S_NUMY: begin
          numy_r <= {gy_prod[48:0], 14'b0};
          remx_r <= '0;
          remy_r <= '0;
          cnt_r  <= '0;
        end
        S_DIV: begin
          if (rx_sh >= den_r) begin
            remx_r <= rx_sh - den_r;
            qx_r   <= {qx_r[61:0], 1'b1};
          end else begin
            remx_r <= rx_sh;
            qx_r   <= {qx_r[61:0], 1'b0};
          end
          if (ry_sh >= den_r) begin
            remy_r <= ry_sh - den_r;
            qy_r   <= {qy_r[61:0], 1'b1};
          end else begin
            remy_r <= ry_sh;
            qy_r   <= {qy_r[61:0], 1'b0};
          end
          numx_r <= {numx_r[61:0], 1'b0};
          numy_r <= {numy_r[61:0], 1'b0};
          cnt_r  <= cnt_r + 6'd1;
        end
        S_OUT: begin
          rsp.last <= q_r.last;
          if (ax2_r == '0 && ay2_r == '0) begin
            rsp.tx  <= q_r.neg ? -33'sd2147483647 : 33'sd2147483647;
            rsp.ty  <= '0;
            rsp.sat <= 1'b1;
          end else begin
            rsp.sat <= ovx || ovy;
            rsp.tx  <= (q_r.sx != q_r.neg) ? -$signed({2'b0, magx}) : $signed({2'b0, magx});
            rsp.ty  <= (q_r.sy != q_r.neg) ? -$signed({2'b0, magy}) : $signed({2'b0, magy});
          end
        end
        default: ;
      endcase
    end
  end
endmodule

/* sv/cfa_checker.sv */
module cfa_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input cfa_pkg::out_item_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped under stall");
  a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown(out_data))
    else $error("unknown result payload");
  a_ready_after_reset: assert property (@(posedge clk)
    $rose(rst_n) |-> in_ready)
    else $error("input not ready after reset");
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");
endmodule

bind coulomb_field_accumulator_top cfa_checker u_cfa_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
